>>> rtl/core/cps_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the column predicate scan
// no dependencies; imported by every module of the block
package cps_pkg;

    localparam int CODE_W  = 32;
    localparam int RESULT_W = 64;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;

    localparam logic [2:0] CMP_EQ = 3'd0;
    localparam logic [2:0] CMP_NE = 3'd1;
    localparam logic [2:0] CMP_GT = 3'd2;
    localparam logic [2:0] CMP_LT = 3'd3;
    localparam logic [2:0] CMP_GE = 3'd4;
    localparam logic [2:0] CMP_LE = 3'd5;

    localparam logic [1:0] COMB_SET = 2'd0;
    localparam logic [1:0] COMB_AND = 2'd1;
    localparam logic [1:0] COMB_OR  = 2'd2;

    localparam logic [1:0] REG_COMPARE_OP     = 2'd0;
    localparam logic [1:0] REG_COMBINE_OP     = 2'd1;
    localparam logic [1:0] REG_OPERAND_SOURCE = 2'd2;
    localparam logic [1:0] REG_LITERAL_CODE   = 2'd3;

    typedef struct packed {
        logic [2:0]        compare_op;
        logic [1:0]        combine_op;
        logic              operand_source;
        logic [CODE_W-1:0] literal_code;
    } t_cfg;

endpackage

>>> rtl/core/cps_regs.sv
`timescale 1ns / 1ps
// configuration registers behind the apb-style port
// depends on cps_pkg
module cps_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [cps_pkg::APB_AW-1:0] i_paddr,
    input  logic [cps_pkg::APB_DW-1:0] i_pwdata,
    output logic [cps_pkg::APB_DW-1:0] o_prdata,
    output cps_pkg::t_cfg              o_cfg
);
    import cps_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign w_wr  = i_psel && i_penable && i_pwrite;
    assign w_idx = i_paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_COMPARE_OP:     r_cfg.compare_op     <= i_pwdata[2:0];
                REG_COMBINE_OP:     r_cfg.combine_op     <= i_pwdata[1:0];
                REG_OPERAND_SOURCE: r_cfg.operand_source <= i_pwdata[0];
                REG_LITERAL_CODE:   r_cfg.literal_code   <= i_pwdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_COMPARE_OP:     o_prdata = APB_DW'(r_cfg.compare_op);
            REG_COMBINE_OP:     o_prdata = APB_DW'(r_cfg.combine_op);
            REG_OPERAND_SOURCE: o_prdata = APB_DW'(r_cfg.operand_source);
            REG_LITERAL_CODE:   o_prdata = APB_DW'(r_cfg.literal_code);
            default:            o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/cps_compare.sv
`timescale 1ns / 1ps
// operand select and six-way unsigned comparator, one predicate bit out
// depends on cps_pkg
module cps_compare #(
    parameter int CODE_BITS = 32
) (
    input  cps_pkg::t_cfg              i_cfg,
    input  logic [cps_pkg::CODE_W-1:0] i_column_code,
    input  logic [cps_pkg::CODE_W-1:0] i_other_code,
    input  logic                       i_code_present,
    output logic                       o_bit
);
    import cps_pkg::*;

    localparam int CMP_BITS = (CODE_BITS < CODE_W) ? CODE_BITS : CODE_W;

    logic [CMP_BITS-1:0] w_a;
    logic [CMP_BITS-1:0] w_b;
    logic                w_eq;
    logic                w_lt;
    logic                w_hit;

    assign w_a  = i_column_code[CMP_BITS-1:0];
    assign w_b  = i_cfg.operand_source ? i_other_code[CMP_BITS-1:0]
                                       : i_cfg.literal_code[CMP_BITS-1:0];
    assign w_eq = (w_a == w_b);
    assign w_lt = (w_a < w_b);

    always_comb begin
        case (i_cfg.compare_op)
            CMP_EQ:  w_hit = w_eq;
            CMP_NE:  w_hit = !w_eq;
            CMP_GT:  w_hit = !w_lt && !w_eq;
            CMP_LT:  w_hit = w_lt;
            CMP_GE:  w_hit = !w_lt;
            CMP_LE:  w_hit = w_lt || w_eq;
            default: w_hit = 1'b0;
        endcase
    end

    assign o_bit = i_code_present && w_hit;

endmodule

>>> rtl/core/cps_pack.sv
`timescale 1ns / 1ps
// bit packer: msb-first word accumulation, word end detect, combine with prior word
// depends on cps_pkg
module cps_pack #(
    parameter int WORD_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_bit,
    input  logic                 i_code_present,
    input  logic                 i_last,
    input  logic [WORD_BITS-1:0] i_prior_word,
    input  logic [1:0]           i_combine_op,
    output logic                 o_word_end,
    output logic [WORD_BITS-1:0] o_word
);
    import cps_pkg::*;

    localparam int                  POS_BITS = $clog2(WORD_BITS);
    localparam logic [POS_BITS-1:0] POS_TOP  = POS_BITS'(WORD_BITS - 1);

    logic [WORD_BITS-1:0] r_packed;
    logic [POS_BITS-1:0]  r_pos;
    logic                 r_any;
    logic [WORD_BITS-1:0] w_packed;
    logic                 w_any;

    assign w_packed   = r_packed | (WORD_BITS'(i_bit) << (POS_TOP - r_pos));
    assign w_any      = r_any || i_code_present;
    assign o_word_end = (r_pos == POS_TOP) || i_last;

    always_comb begin
        if (!w_any) begin
            o_word = '0;
        end else begin
            case (i_combine_op)
                COMB_AND: o_word = w_packed & i_prior_word;
                COMB_OR:  o_word = w_packed | i_prior_word;
                default:  o_word = w_packed;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packed <= '0;
            r_pos    <= '0;
            r_any    <= 1'b0;
        end else if (i_step) begin
            if (o_word_end) begin
                r_packed <= '0;
                r_pos    <= '0;
                r_any    <= 1'b0;
            end else begin
                r_packed <= w_packed;
                r_pos    <= r_pos + POS_BITS'(1);
                r_any    <= w_any;
            end
        end
    end

endmodule

>>> rtl/core/column_predicate_scan.sv
`timescale 1ns / 1ps
// column predicate scan top level: input register, compare and pack, result register
// depends on cps_pkg, cps_regs, cps_compare, cps_pack
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------------
//  input    | i_in_valid / o_in_stall   | column_code, other_code, code_present,
//           |                           | prior_word, last
//  output   | o_out_valid / i_out_stall | result_word, is_final
//  config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// one transaction per cycle sustained unless a closed word waits on a stalled result;
// a word's closing transaction passes the input register, then the result register
// synchronous active-low reset clears the pipeline valids, the packer and the config
// a stalled result holds in the result register; the input register still absorbs one
// transaction and keeps advancing as long as it does not close a word
module column_predicate_scan #(
    parameter int WORD_BITS = 64,
    parameter int CODE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [cps_pkg::CODE_W-1:0]          i_column_code,
    input  logic [cps_pkg::CODE_W-1:0]          i_other_code,
    input  logic                                i_code_present,
    input  logic [cps_pkg::RESULT_W-1:0]        i_prior_word,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [cps_pkg::RESULT_W-1:0]        o_result_word,
    output logic                                o_is_final,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cps_pkg::APB_AW-1:0]          paddr,
    input  logic [cps_pkg::APB_DW-1:0]          pwdata,
    output logic [cps_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);
    import cps_pkg::*;

    t_cfg                 w_cfg;
    logic                 r_s1_valid;
    logic [CODE_W-1:0]    r_col;
    logic [CODE_W-1:0]    r_oth;
    logic                 r_present;
    logic [WORD_BITS-1:0] r_prior;
    logic                 r_last;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_res_word;
    logic                 r_res_final;
    logic                 w_bit;
    logic                 w_word_end;
    logic [WORD_BITS-1:0] w_word;
    logic                 w_out_free;
    logic                 w_s1_adv;
    logic                 w_in_acc;

    assign pready = 1'b1;

    cps_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_adv   = r_s1_valid && (!w_word_end || w_out_free);
    assign o_in_stall = r_s1_valid && !w_s1_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_col     <= i_column_code;
            r_oth     <= i_other_code;
            r_present <= i_code_present;
            r_prior   <= i_prior_word[WORD_BITS-1:0];
            r_last    <= i_last;
        end
    end

    cps_compare #(
        .CODE_BITS (CODE_BITS)
    ) u_compare (
        .i_cfg          (w_cfg),
        .i_column_code  (r_col),
        .i_other_code   (r_oth),
        .i_code_present (r_present),
        .o_bit          (w_bit)
    );

    cps_pack #(
        .WORD_BITS (WORD_BITS)
    ) u_pack (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_s1_adv),
        .i_bit          (w_bit),
        .i_code_present (r_present),
        .i_last         (r_last),
        .i_prior_word   (r_prior),
        .i_combine_op   (w_cfg.combine_op),
        .o_word_end     (w_word_end),
        .o_word         (w_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv && w_word_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && w_word_end) begin
            r_res_word  <= w_word;
            r_res_final <= r_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_word = RESULT_W'(r_res_word);
    assign o_is_final    = r_res_final;

    a_word_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && w_word_end) |=> o_out_valid)
        else $error("closed word did not reach the result register");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && w_word_end && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked word end");

    a_partial_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && !w_word_end && !(r_out_valid && i_out_stall)) |=> !o_out_valid)
        else $error("result emitted for a position inside a word");

endmodule

>>> verif/cps_scan_checker.sv
`timescale 1ns / 1ps
// scoreboard for column_predicate_scan: mirrors the config port, predicts every packed
// word from the input transactions and compares it with the output transactions
// depends on cps_pkg
module cps_scan_checker #(
    parameter int WORD_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [cps_pkg::CODE_W-1:0]   i_column_code,
    input  logic [cps_pkg::CODE_W-1:0]   i_other_code,
    input  logic                         i_code_present,
    input  logic [cps_pkg::RESULT_W-1:0] i_prior_word,
    input  logic                         i_last,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [cps_pkg::RESULT_W-1:0] i_result_word,
    input  logic                         i_is_final,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic                         i_pready,
    input  logic [cps_pkg::APB_AW-1:0]   i_paddr,
    input  logic [cps_pkg::APB_DW-1:0]   i_pwdata,
    output int                           o_mismatches,
    output int                           o_words_pending,
    output int                           o_words_seen
);
    import cps_pkg::*;

    typedef struct {
        logic [RESULT_W-1:0] word;
        logic                is_final;
    } t_scan_word;

    localparam logic [RESULT_W-1:0] WORD_MASK = {RESULT_W{1'b1}} >> (RESULT_W - WORD_BITS);

    t_cfg                cfg;
    logic [RESULT_W-1:0] packed_bits;
    int unsigned         bit_pos;
    logic                any_present;
    t_scan_word          expected_words[$];
    int                  mismatches;
    int                  words_seen;

    function automatic logic predicate_hit(input logic [2:0] op,
                                           input logic [CODE_W-1:0] a,
                                           input logic [CODE_W-1:0] b);
        case (op)
            CMP_EQ: return a == b;
            CMP_NE: return a != b;
            CMP_GT: return a > b;
            CMP_LT: return a < b;
            CMP_GE: return a >= b;
            CMP_LE: return a <= b;
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [RESULT_W-1:0] got,
                                   input logic [RESULT_W-1:0] want);
        $display("%0t ns mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic scan_position(input logic [CODE_W-1:0] col, input logic [CODE_W-1:0] oth,
                                 input logic present, input logic [RESULT_W-1:0] prior,
                                 input logic last);
        logic [CODE_W-1:0] operand;
        t_scan_word        closed;
        operand = cfg.operand_source ? oth : cfg.literal_code;
        if (present) begin
            any_present = 1'b1;
            if (predicate_hit(cfg.compare_op, col, operand))
                packed_bits[WORD_BITS-1-bit_pos] = 1'b1;
        end
        if (bit_pos + 1 < WORD_BITS && !last) begin
            bit_pos++;
        end else begin
            if (!any_present) begin
                closed.word = '0;
            end else begin
                case (cfg.combine_op)
                    COMB_AND: closed.word = packed_bits & prior;
                    COMB_OR:  closed.word = packed_bits | prior;
                    default:  closed.word = packed_bits;
                endcase
            end
            closed.word    = closed.word & WORD_MASK;
            closed.is_final = last;
            expected_words.push_back(closed);
            packed_bits = '0;
            bit_pos     = 0;
            any_present = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_scan_word oldest;
        if (!i_rst_n) begin
            cfg         = '0;
            packed_bits = '0;
            bit_pos     = 0;
            any_present = 1'b0;
            mismatches  = 0;
            words_seen  = 0;
            expected_words.delete();
        end else begin
            // results first: a word closed at this edge cannot leave before the next one
            if (i_out_valid && !i_out_stall) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected result word", i_result_word, '0);
                end else begin
                    oldest = expected_words.pop_front();
                    if (i_result_word !== oldest.word)
                        report_mismatch("result_word", i_result_word, oldest.word);
                    if (i_is_final !== oldest.is_final)
                        report_mismatch("is_final", 64'(i_is_final), 64'(oldest.is_final));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_COMPARE_OP:     cfg.compare_op     = i_pwdata[2:0];
                    REG_COMBINE_OP:     cfg.combine_op     = i_pwdata[1:0];
                    REG_OPERAND_SOURCE: cfg.operand_source = i_pwdata[0];
                    REG_LITERAL_CODE:   cfg.literal_code   = i_pwdata[CODE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                scan_position(i_column_code, i_other_code, i_code_present, i_prior_word, i_last);
        end
        o_mismatches    <= mismatches;
        o_words_pending <= expected_words.size();
        o_words_seen    <= words_seen;
    end

endmodule

>>> verif/tb_column_predicate_scan.sv
`timescale 1ns / 1ps
// top of the column_predicate_scan testbench: clock, reset, config writes, input stream
// and output backpressure; depends on cps_pkg, column_predicate_scan and cps_scan_checker
module tb_column_predicate_scan;
    import cps_pkg::*;

    localparam int         ITEM_TARGET   = 1700;
    localparam int         SETTLE_CYCLES = 4;
    localparam logic [2:0] CMP_UNDEF_LO  = 3'd6;
    localparam logic [2:0] CMP_UNDEF_HI  = 3'd7;
    localparam logic [1:0] COMB_UNDEF    = 2'd3;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic [CODE_W-1:0]   i_column_code  = '0;
    logic [CODE_W-1:0]   i_other_code   = '0;
    logic                i_code_present = 1'b0;
    logic [RESULT_W-1:0] i_prior_word   = '0;
    logic                i_last         = 1'b0;
    logic                i_out_stall    = 1'b0;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [APB_AW-1:0]   paddr          = '0;
    logic [APB_DW-1:0]   pwdata         = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [RESULT_W-1:0] o_result_word;
    logic                o_is_final;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int                  mismatches;
    int                  words_pending;
    int                  words_seen;
    int                  items_sent     = 0;
    int                  settings_used  = 0;
    bit                  tx_quiet       = 1'b0;
    bit                  rx_quiet       = 1'b0;
    int                  rx_wait        = 0;
    int                  rx_draw;
    logic                cur_src        = 1'b0;
    logic [CODE_W-1:0]   cur_lit        = '0;

    column_predicate_scan DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_column_code  (i_column_code),
        .i_other_code   (i_other_code),
        .i_code_present (i_code_present),
        .i_prior_word   (i_prior_word),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_word  (o_result_word),
        .o_is_final     (o_is_final),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    cps_scan_checker u_scoreboard (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_column_code   (i_column_code),
        .i_other_code    (i_other_code),
        .i_code_present  (i_code_present),
        .i_prior_word    (i_prior_word),
        .i_last          (i_last),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_result_word   (o_result_word),
        .i_is_final      (o_is_final),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_mismatches    (mismatches),
        .o_words_pending (words_pending),
        .o_words_seen    (words_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: after each transaction hold stall for a random number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wait     <= 0;
            i_out_stall <= 1'b0;
        end else if (o_out_valid && !i_out_stall) begin
            rx_draw = rx_quiet ? 0 : $urandom_range(0, 7);
            rx_wait     <= rx_draw;
            i_out_stall <= (rx_draw != 0);
        end else if (rx_wait > 0) begin
            rx_wait     <= rx_wait - 1;
            i_out_stall <= (rx_wait > 1);
        end
    end

    task automatic write_reg(input logic [1:0] index, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [2:0] cmp, input logic [1:0] comb,
                                input logic src, input logic [CODE_W-1:0] lit);
        logic [APB_DW-1:0] junk;
        wait_drained();
        // unused upper bits of the narrow registers get random content now and then
        junk = ($urandom_range(0, 3) == 0) ? $urandom : '0;
        write_reg(REG_COMPARE_OP, (junk & ~32'h7) | 32'(cmp));
        write_reg(REG_COMBINE_OP, (junk & ~32'h3) | 32'(comb));
        write_reg(REG_OPERAND_SOURCE, (junk & ~32'h1) | 32'(src));
        write_reg(REG_LITERAL_CODE, lit);
        cur_src = src;
        cur_lit = lit;
        settings_used++;
    endtask

    task automatic send_item(input logic [CODE_W-1:0] col, input logic [CODE_W-1:0] oth,
                             input logic present, input logic [RESULT_W-1:0] prior,
                             input logic lst);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_column_code  <= col;
        i_other_code   <= oth;
        i_code_present <= present;
        i_prior_word   <= prior;
        i_last         <= lst;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic [CODE_W-1:0] near_code(input logic [CODE_W-1:0] base);
        case ($urandom_range(0, 6))
            0: return base;
            1: return base + 1;
            2: return base - 1;
            3: return '0;
            4: return '1;
            5: return base ^ (32'd1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [RESULT_W-1:0] rand_prior();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one bitvector: present codes up to the column end, absent ones after it, last at the end
    task automatic send_bitvector();
        int                len;
        int                col_len;
        logic [CODE_W-1:0] col;
        logic [CODE_W-1:0] oth;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 200) : $urandom_range(1, 40);
        case ($urandom_range(0, 5))
            0: col_len = 0;
            1: col_len = $urandom_range(0, len);
            default: col_len = len;
        endcase
        for (int p = 0; p < len; p++) begin
            col = near_code(cur_src ? $urandom : cur_lit);
            oth = cur_src ? near_code(col) : $urandom;
            send_item(col, oth, p < col_len, rand_prior(), p == len - 1);
        end
    endtask

    initial begin
        int   phase_end;
        logic [2:0] cmp;
        logic [1:0] comb;
        logic [CODE_W-1:0] lit;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: equal against literal zero, short word closed by last
        send_item(32'd0, 32'd0, 1'b1, '1, 1'b0);
        send_item(32'hFFFF_FFFF, 32'd0, 1'b1, '1, 1'b0);
        send_item(32'd0, 32'd0, 1'b0, '1, 1'b0);
        send_item(32'd0, 32'd7, 1'b1, '1, 1'b1);

        // word with nothing present ignores the prior word
        apply_config(CMP_EQ, COMB_OR, 1'b0, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'd0, 1'b0, '1, 1'b1);
        send_item(32'hFFFF_FFFF, 32'd0, 1'b1, 64'h5555_5555_5555_5555, 1'b1);

        for (int op = CMP_NE; op <= CMP_LE; op++) begin
            apply_config(3'(op), COMB_AND, 1'b1, 32'd0);
            send_item(32'd5, 32'd5, 1'b1, '1, 1'b0);
            send_item(32'd0, 32'hFFFF_FFFF, 1'b1, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0);
            send_item(32'hFFFF_FFFF, 32'd0, 1'b1, '1, 1'b1);
        end

        // undefined comparator codes give zero bits, undefined combine acts as set
        apply_config(CMP_UNDEF_LO, COMB_OR, 1'b0, 32'd0);
        send_item(32'd0, 32'd0, 1'b1, 64'h0123_4567_89AB_CDEF, 1'b1);
        apply_config(CMP_UNDEF_HI, COMB_UNDEF, 1'b1, 32'd0);
        send_item(32'd3, 32'd3, 1'b1, '1, 1'b1);
        apply_config(CMP_EQ, COMB_UNDEF, 1'b0, 32'd0);
        send_item(32'd0, 32'd0, 1'b1, '0, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            cmp  = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(CMP_UNDEF_LO, CMP_UNDEF_HI))
                                               : 3'($urandom_range(CMP_EQ, CMP_LE));
            comb = ($urandom_range(0, 7) == 0) ? COMB_UNDEF
                                               : 2'($urandom_range(COMB_SET, COMB_OR));
            case ($urandom_range(0, 3))
                0: lit = '0;
                1: lit = '1;
                2: lit = $urandom_range(0, 15);
                default: lit = $urandom;
            endcase
            apply_config(cmp, comb, 1'($urandom_range(0, 1)), lit);
            tx_quiet  = ($urandom_range(0, 3) == 0);
            rx_quiet <= ($urandom_range(0, 3) == 0);
            phase_end = items_sent + $urandom_range(60, 140);
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 9) < 8)
                    send_bitvector();
                else
                    send_item($urandom, $urandom, 1'($urandom_range(0, 1)), rand_prior(),
                              $urandom_range(0, 7) == 0);
                if ($urandom_range(0, 40) == 0)
                    wait_drained();
            end
            // close any open word before the next register change
            send_item($urandom, $urandom, 1'($urandom_range(0, 1)), rand_prior(), 1'b1);
        end

        wait_drained();
        $display("covered %0d input transactions and %0d result words over %0d register settings",
                 items_sent, words_seen, settings_used);
        $display("all comparators, undefined codes, absent positions, short and full words");
        if (mismatches == 0 && words_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
